>>> hw/rtl/sbm_pkg.sv
package sbm_pkg;

    localparam int SBM_SAMPLE_BITS    = 24;
    localparam int SBM_GAIN_FRAC_BITS = 16;
    localparam int SBM_CFG_IDX_BITS   = 3;
    localparam int SBM_CFG_DATA_BITS  = 16;
    localparam int SBM_POS_BITS       = 16;
    localparam int SBM_LAW_BITS       = 15;

    // center level limits, Q0.15
    localparam logic [SBM_LAW_BITS-1:0] SBM_LAW_MIN = 15'd16384;
    localparam logic [SBM_LAW_BITS-1:0] SBM_LAW_MAX = 15'd23170;

    typedef enum logic [SBM_CFG_IDX_BITS-1:0] {
        REG_BALANCE   = 3'd0,
        REG_LEFT_POS  = 3'd1,
        REG_RIGHT_POS = 3'd2,
        REG_LAW       = 3'd3,
        REG_MONO      = 3'd4
    } t_sbm_reg;

    typedef enum logic [2:0] {
        GS_IDLE,
        GS_TERM,
        GS_LEVEL,
        GS_STORE,
        GS_DIV,
        GS_MATRIX
    } t_sbm_gstate;

    typedef struct packed {
        logic signed [SBM_SAMPLE_BITS-1:0] in_left;
        logic signed [SBM_SAMPLE_BITS-1:0] in_right;
    } t_sbm_in;

    typedef struct packed {
        logic signed [SBM_SAMPLE_BITS-1:0] out_left;
        logic signed [SBM_SAMPLE_BITS-1:0] out_right;
    } t_sbm_out;

endpackage

>>> hw/rtl/sbm_gain_calc.sv
module sbm_gain_calc #(
    parameter int GAIN_FRAC_BITS = sbm_pkg::SBM_GAIN_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr,
    input  logic [sbm_pkg::SBM_CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sbm_pkg::SBM_CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                                   o_gain_ok,
    output logic                                   o_mono,
    output logic [GAIN_FRAC_BITS+1:0]              o_g_l2l,
    output logic [GAIN_FRAC_BITS+1:0]              o_g_l2r,
    output logic [GAIN_FRAC_BITS+1:0]              o_g_r2l,
    output logic [GAIN_FRAC_BITS+1:0]              o_g_r2r
);
    import sbm_pkg::*;

    localparam int G  = GAIN_FRAC_BITS;
    localparam int QW = G + 2;          // gain width, Q2.G
    localparam int VW = 46;             // level in Q45, at most 2^45
    localparam int NW = 47;             // level plus rounding half
    localparam int DW = 45 - G;         // divisor law * 2^(30-G)
    localparam int CW = $clog2(QW);
    localparam logic [2:0] LAST_BAL = 3'd1;
    localparam logic [2:0] LAST_POS = 3'd5;
    localparam logic [1:0] LAST_MAT = 2'd3;

    // configuration registers
    logic signed [SBM_POS_BITS-1:0] r_bal_pos;
    logic signed [SBM_POS_BITS-1:0] r_left_pos;
    logic signed [SBM_POS_BITS-1:0] r_right_pos;
    logic [SBM_LAW_BITS-1:0]        r_law;
    logic                           r_mono;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bal_pos   <= '0;
            r_left_pos  <= -16'sd32767;
            r_right_pos <= 16'sd32767;
            r_law       <= SBM_LAW_MIN;
            r_mono      <= 1'b0;
        end else if (i_cfg_wr) begin
            case (t_sbm_reg'(i_cfg_index))
                REG_BALANCE:   r_bal_pos   <= i_cfg_data;
                REG_LEFT_POS:  r_left_pos  <= i_cfg_data;
                REG_RIGHT_POS: r_right_pos <= i_cfg_data;
                REG_LAW:       r_law       <= i_cfg_data[SBM_LAW_BITS-1:0];
                REG_MONO:      r_mono      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_sbm_gstate r_state, n_state;
    logic [2:0]                r_k, n_k;
    logic [1:0]                r_j, n_j;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic signed [31:0]        r_t, n_t;
    logic [VW-1:0]             r_v, n_v;
    logic [DW-1:0]             r_rem, n_rem;
    logic [QW-1:0]             r_dq, n_dq;
    logic [QW-1:0]             r_pan [4];
    logic [QW-1:0]             n_pan [4];
    logic [QW-1:0]             r_bal [2];
    logic [QW-1:0]             n_bal [2];
    logic [QW-1:0]             r_mat [4];
    logic [QW-1:0]             n_mat [4];

    logic [SBM_LAW_BITS-1:0]   w_law;
    logic signed [16:0]        w_p;
    logic signed [16:0]        w_c2;
    logic signed [33:0]        w_t_full;
    logic signed [48:0]        w_v_full;
    logic [NW-1:0]             w_pan_sum;
    logic [NW-1:0]             w_num;
    logic [DW-1:0]             w_den;
    logic [DW:0]               w_rem_sh;
    logic [DW+1:0]             w_diff;
    logic                      w_ge;
    logic [2*QW-1:0]           w_mprod;

    always_comb begin
        if (r_law < SBM_LAW_MIN) begin
            w_law = SBM_LAW_MIN;
        end else if (r_law > SBM_LAW_MAX) begin
            w_law = SBM_LAW_MAX;
        end else begin
            w_law = r_law;
        end
    end

    // positions in order: balance, -balance, left, -left, right, -right
    always_comb begin
        case (r_k)
            3'd0:    w_p = 17'(r_bal_pos);
            3'd1:    w_p = -17'(r_bal_pos);
            3'd2:    w_p = 17'(r_left_pos);
            3'd3:    w_p = -17'(r_left_pos);
            3'd4:    w_p = 17'(r_right_pos);
            3'd5:    w_p = -17'(r_right_pos);
            default: w_p = '0;
        endcase
    end

    assign w_c2      = 17'sd16384 - $signed({2'b00, w_law});
    assign w_t_full  = 34'(w_c2) * 34'(w_p);
    assign w_v_full  = 49'(r_t) * 49'(w_p) + $signed(49'({w_law, 30'd0}));
    assign w_pan_sum = NW'(r_v) + (NW'(1) << (44 - G));
    assign w_num     = NW'(r_v) + (NW'(w_law) << (29 - G));
    assign w_den     = DW'(w_law) << (30 - G);
    assign w_rem_sh  = {r_rem, r_dq[QW-1]};
    assign w_diff    = {1'b0, w_rem_sh} - {2'b00, w_den};
    assign w_ge      = !w_diff[DW+1];
    assign w_mprod   = (2*QW)'(r_pan[r_j]) * (2*QW)'(r_bal[r_j[0]])
                       + ((2*QW)'(1) << (G - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= GS_TERM;
            r_k     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_v   <= n_v;
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_pan <= n_pan;
        r_bal <= n_bal;
        r_mat <= n_mat;
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_j     = r_j;
        n_cnt   = r_cnt;
        n_t     = r_t;
        n_v     = r_v;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_pan   = r_pan;
        n_bal   = r_bal;
        n_mat   = r_mat;
        case (r_state)
            GS_IDLE: ;
            GS_TERM: begin
                n_t     = 32'(w_t_full) - 32'sd536870912;
                n_state = GS_LEVEL;
            end
            GS_LEVEL: begin
                // level never below zero
                n_v     = w_v_full[48] ? '0 : w_v_full[VW-1:0];
                n_state = GS_STORE;
            end
            GS_STORE: begin
                if (r_k <= LAST_BAL) begin
                    n_rem   = w_num[NW-1:QW];
                    n_dq    = w_num[QW-1:0];
                    n_cnt   = '0;
                    n_state = GS_DIV;
                end else begin
                    n_pan[2'(r_k - 3'd2)] = QW'(w_pan_sum >> (45 - G));
                    if (r_k == LAST_POS) begin
                        n_j     = '0;
                        n_state = GS_MATRIX;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = GS_TERM;
                    end
                end
            end
            GS_DIV: begin
                n_rem = w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
                n_dq  = {r_dq[QW-2:0], w_ge};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(QW - 1)) begin
                    n_bal[r_k[0]] = {r_dq[QW-2:0], w_ge};
                    n_k           = r_k + 3'd1;
                    if (r_k == LAST_BAL && r_mono) begin
                        n_state = GS_IDLE;
                    end else begin
                        n_state = GS_TERM;
                    end
                end
            end
            GS_MATRIX: begin
                n_mat[r_j] = QW'(w_mprod >> G);
                n_j        = r_j + 2'd1;
                if (r_j == LAST_MAT) begin
                    n_state = GS_IDLE;
                end
            end
            default: n_state = GS_TERM;
        endcase
        // any register write recomputes every gain
        if (i_cfg_wr) begin
            n_state = GS_TERM;
            n_k     = '0;
        end
    end

    assign o_gain_ok = (r_state == GS_IDLE);
    assign o_mono    = r_mono;
    assign o_g_l2l   = r_mono ? r_bal[0] : r_mat[0];
    assign o_g_l2r   = r_mono ? r_bal[1] : r_mat[1];
    assign o_g_r2l   = r_mono ? '0 : r_mat[2];
    assign o_g_r2r   = r_mono ? '0 : r_mat[3];

endmodule

>>> hw/rtl/sbm_mix_pipe.sv
module sbm_mix_pipe #(
    parameter int GAIN_FRAC_BITS = sbm_pkg::SBM_GAIN_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_gain_ok,
    input  logic [GAIN_FRAC_BITS+1:0]     i_g_l2l,
    input  logic [GAIN_FRAC_BITS+1:0]     i_g_l2r,
    input  logic [GAIN_FRAC_BITS+1:0]     i_g_r2l,
    input  logic [GAIN_FRAC_BITS+1:0]     i_g_r2r,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sbm_pkg::t_sbm_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sbm_pkg::t_sbm_out             o_out_data
);
    import sbm_pkg::*;

    localparam int S  = SBM_SAMPLE_BITS;
    localparam int G  = GAIN_FRAC_BITS;
    localparam int QW = G + 2;
    localparam int PW = S + QW;
    localparam int SW = PW + 1;
    localparam int AW = SW - G;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    logic signed [S-1:0]  r_xl, r_xr;
    logic signed [PW-1:0] r_p_ll, r_p_rl, r_p_lr, r_p_rr;
    logic signed [AW-1:0] r_acc_l, r_acc_r;
    t_sbm_out             r_out;

    logic signed [SW-1:0] w_sum_l, w_sum_r;
    logic signed [S-1:0]  w_sat_l, w_sat_r;

    assign w_en4      = !r_v4 || i_out_ready;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1 && i_gain_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid && i_gain_ok;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: capture samples
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_xl <= i_in_data.in_left;
            r_xr <= i_in_data.in_right;
        end
    end

    // stage 2: four matrix products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_p_ll <= PW'(r_xl) * PW'($signed({1'b0, i_g_l2l}));
            r_p_rl <= PW'(r_xr) * PW'($signed({1'b0, i_g_r2l}));
            r_p_lr <= PW'(r_xl) * PW'($signed({1'b0, i_g_l2r}));
            r_p_rr <= PW'(r_xr) * PW'($signed({1'b0, i_g_r2r}));
        end
    end

    // stage 3: sum, round half up, drop the fraction
    assign w_sum_l = SW'(r_p_ll) + SW'(r_p_rl) + (SW'(1) << (G - 1));
    assign w_sum_r = SW'(r_p_lr) + SW'(r_p_rr) + (SW'(1) << (G - 1));

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_acc_l <= w_sum_l[SW-1:G];
            r_acc_r <= w_sum_r[SW-1:G];
        end
    end

    // stage 4: saturate into the output register
    always_comb begin
        if (r_acc_l[AW-1:S-1] == '0 || r_acc_l[AW-1:S-1] == '1) begin
            w_sat_l = r_acc_l[S-1:0];
        end else begin
            w_sat_l = r_acc_l[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
        end
        if (r_acc_r[AW-1:S-1] == '0 || r_acc_r[AW-1:S-1] == '1) begin
            w_sat_r = r_acc_r[S-1:0];
        end else begin
            w_sat_r = r_acc_r[AW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out.out_left  <= w_sat_l;
            r_out.out_right <= w_sat_r;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

endmodule

>>> hw/rtl/stereo_pan_balance_mixer_top.sv
// stereo pan and balance mixer, quadratic pan law
// channels: input pair (i_in_valid / o_in_ready / i_in_data), mixed pair
// (o_out_valid / i_out_ready / o_out_data) and a register write port
// (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data), always ready
// a transfer on the input enters a four stage pipeline: capture, products,
// sum and round, saturate into the output register
// throughput is one pair per cycle while the output is not stalled and the
// gains are ready, set by the four product multipliers
// gains are computed by a sequencer with its own small multipliers and a bit
// serial divider; it runs after reset and after every register write, with the
// pan and matrix steps skipped in mono mode, and o_in_ready stays low until
// it is done
// reset loads the register defaults and starts the gain sequence
// when the receiver stalls, stages fill up behind the output register
// and o_in_ready falls once every stage holds a pair; nothing is dropped
module stereo_pan_balance_mixer_top #(
    parameter int GAIN_FRAC_BITS = sbm_pkg::SBM_GAIN_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [sbm_pkg::SBM_CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [sbm_pkg::SBM_CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  sbm_pkg::t_sbm_in                       i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output sbm_pkg::t_sbm_out                      o_out_data
);
    import sbm_pkg::*;

    localparam int QW = GAIN_FRAC_BITS + 2;
    localparam logic [QW-1:0] GAIN_MAX = QW'(1) << (GAIN_FRAC_BITS + 1);

    logic          w_gain_ok;
    logic          w_mono;
    logic [QW-1:0] w_g_l2l, w_g_l2r, w_g_r2l, w_g_r2r;

    assign o_cfg_ready = 1'b1;

    sbm_gain_calc #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_gain_ok   (w_gain_ok),
        .o_mono      (w_mono),
        .o_g_l2l     (w_g_l2l),
        .o_g_l2r     (w_g_l2r),
        .o_g_r2l     (w_g_r2l),
        .o_g_r2r     (w_g_r2r)
    );

    sbm_mix_pipe #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain_ok   (w_gain_ok),
        .i_g_l2l     (w_g_l2l),
        .i_g_l2r     (w_g_l2r),
        .i_g_r2l     (w_g_r2l),
        .i_g_r2r     (w_g_r2r),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input accepted right after reset");

    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_in_ready)
        else $error("input accepted while gains are recomputed");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gain_ok |-> (w_g_l2l <= GAIN_MAX && w_g_l2r <= GAIN_MAX
                       && w_g_r2l <= GAIN_MAX && w_g_r2r <= GAIN_MAX))
        else $error("gain above 2.0");

    a_mono_right_muted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_gain_ok && w_mono) |-> (w_g_r2l == '0 && w_g_r2r == '0))
        else $error("right input leaks in mono mode");
`endif

endmodule
